>>> src/ilwc_pkg.sv
package ilwc_pkg;

    localparam int MAX_WAYPOINTS_DEF = 64;
    localparam int MAX_SAMPLES_DEF   = 2048;
    localparam int COORD_WIDTH_DEF   = 16;

    localparam int IDX_W      = 6;
    localparam int GAIN_W     = 15;
    localparam int THR_W      = 16;
    localparam int TICK_W     = 16;
    localparam int PASS_W     = 16;
    localparam int FRAC_BITS  = 12;
    localparam int ROUND_HALF = 2048;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [GAIN_W-1:0] GAIN_RST      = 15'd2048;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd20;
    localparam logic [IDX_W-1:0]  LAST_WP_RST   = 6'd49;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN      = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_LAST_WP   = 2'd2
    } cfg_reg_t;

endpackage

>>> src/iterative_learning_waypoint_control_unit.sv
// Iterative learning waypoint controller.
// Configuration: cfg_we/cfg_addr/cfg_wdata, one register write per cycle,
// to be used only while no transaction is in flight.
// Input channel (s_*): valid/ready. req_type 0 loads one path table entry
// and gives no result; req_type 1 is a control tick. A tick with control_on
// low gives no result and leaves the state alone. Every other tick gives
// exactly one result transaction on the m_* channel.
// Throughput: one transaction per cycle while s_ready is high. Each tick
// reads the path table once; a tick with waypoints_on high also does one
// read-modify-write of the sample memories. The command write-back is made
// from the stage 2 registers and is forwarded to later reads.
// Results drain through a 4-entry output queue. s_ready tracks free queue
// space minus the ticks still in the pipeline, so a stalled receiver first
// fills the queue and then holds s_ready low; nothing is dropped.
// Reset (aresetn low, synchronous) clears the counters, the waypoint and
// sample indexes, the pipeline and the queue, and loads the register
// defaults. The path table and sample memories are not cleared.
module iterative_learning_waypoint_control_unit
    import ilwc_pkg::*;
#(
    parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
    parameter int MAX_SAMPLES   = MAX_SAMPLES_DEF,
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [IDX_W-1:0]              s_entry_index,
    input  logic signed [COORD_WIDTH-1:0] s_want_x,
    input  logic signed [COORD_WIDTH-1:0] s_want_y,
    input  logic signed [COORD_WIDTH-1:0] s_first_x,
    input  logic signed [COORD_WIDTH-1:0] s_first_y,
    input  logic signed [COORD_WIDTH-1:0] s_meas_x,
    input  logic signed [COORD_WIDTH-1:0] s_meas_y,
    input  logic                          s_control_on,
    input  logic                          s_waypoints_on,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_command_x,
    output logic signed [COORD_WIDTH-1:0] m_command_y,
    output logic signed [COORD_WIDTH-1:0] m_error_x,
    output logic signed [COORD_WIDTH-1:0] m_error_y,
    output logic [IDX_W-1:0]              m_waypoint_now,
    output logic [PASS_W-1:0]             m_pass_number,
    output logic                          m_holding,
    output logic                          m_sample_overflow
);

    localparam int CW     = COORD_WIDTH;
    localparam int WP_AW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
    localparam int WP_EW  = (WP_AW > IDX_W) ? WP_AW : IDX_W;
    localparam int SA_W   = $clog2(MAX_SAMPLES);
    localparam int PROD_W = CW + 1 + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RES_W  = 4 * CW + IDX_W + PASS_W + 2;
    localparam logic [SA_W-1:0]    SAMPLE_LAST = SA_W'(MAX_SAMPLES - 1);
    localparam logic [WP_EW:0]     WP_LIMIT    = (WP_EW + 1)'(MAX_WAYPOINTS);
    localparam logic signed [CW-1:0] C_MAX     = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN     = {1'b1, {(CW - 1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_diff(input logic signed [CW:0] v);
        logic signed [CW-1:0] r;
        if (v[CW] != v[CW-1]) begin
            r = v[CW] ? C_MIN : C_MAX;
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-CW:0] upper;
        logic signed [CW-1:0] r;
        upper = v[SUM_W-1:CW-1];
        if ((&upper) || (~|upper)) begin
            r = v[CW-1:0];
        end else begin
            r = v[SUM_W-1] ? C_MIN : C_MAX;
        end
        return r;
    endfunction

    // configuration
    logic [GAIN_W-1:0] gain_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [IDX_W-1:0]  last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RST;
            thr_reg  <= THRESHOLD_RST;
            last_reg <= LAST_WP_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_GAIN:      gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                CFG_LAST_WP:   last_reg <= cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // accept and sequencing state
    logic s_acc, is_load, is_tick, is_run;
    logic [TICK_W-1:0] tick_reg, tick_next, tick_inc;
    logic [IDX_W-1:0]  wp_reg, wp_next;
    logic [SA_W-1:0]   sample_reg, sample_next, use_s;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              started_reg, started_next;
    logic              ovf_now;

    assign s_acc   = s_valid && s_ready;
    assign is_load = (s_req_type == REQ_LOAD);
    assign is_tick = (s_req_type == REQ_TICK) && s_control_on;
    assign is_run  = is_tick && s_waypoints_on;
    assign tick_inc = (tick_reg != '1) ? tick_reg + 1'b1 : tick_reg;

    always_comb begin
        tick_next    = tick_reg;
        wp_next      = wp_reg;
        sample_next  = sample_reg;
        pass_next    = pass_reg;
        started_next = started_reg;
        use_s        = sample_reg;
        ovf_now      = 1'b0;
        if (is_run) begin
            tick_next = tick_inc;
            if (tick_inc > thr_reg) begin
                tick_next = '0;
                if (wp_reg < last_reg) begin
                    if (started_reg) begin
                        wp_next = wp_reg + 1'b1;
                    end
                end else begin
                    wp_next = '0;
                    use_s   = '0;
                    if (pass_reg != '1) begin
                        pass_next = pass_reg + 1'b1;
                    end
                end
            end
            ovf_now      = (use_s == SAMPLE_LAST);
            sample_next  = ovf_now ? use_s : use_s + 1'b1;
            started_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            wp_reg      <= '0;
            sample_reg  <= '0;
            pass_reg    <= '0;
            started_reg <= 1'b0;
        end else if (s_acc && is_run) begin
            tick_reg    <= tick_next;
            wp_reg      <= wp_next;
            sample_reg  <= sample_next;
            pass_reg    <= pass_next;
            started_reg <= started_next;
        end
    end

    // path table
    logic [WP_EW-1:0] rd_wp_ext, ld_wp_ext;
    logic [WP_AW-1:0] rd_wp_addr, ld_wp_addr;
    logic             rd_wp_ok, ld_wp_ok;
    logic [4*CW-1:0]  path_mem [MAX_WAYPOINTS];
    logic [4*CW-1:0]  tbl_rd_reg;

    assign rd_wp_ext  = WP_EW'(wp_next);
    assign ld_wp_ext  = WP_EW'(s_entry_index);
    assign rd_wp_addr = rd_wp_ext[WP_AW-1:0];
    assign ld_wp_addr = ld_wp_ext[WP_AW-1:0];
    assign rd_wp_ok   = ({1'b0, rd_wp_ext} < WP_LIMIT);
    assign ld_wp_ok   = ({1'b0, ld_wp_ext} < WP_LIMIT);

    always_ff @(posedge aclk) begin
        if (s_acc && is_load && ld_wp_ok) begin
            path_mem[ld_wp_addr] <= {s_want_x, s_want_y, s_first_x, s_first_y};
        end
        if (s_acc && is_tick && rd_wp_ok) begin
            tbl_rd_reg <= path_mem[rd_wp_addr];
        end
    end

    // sample memories
    logic [2*CW-1:0] pos_mem [MAX_SAMPLES];
    logic [2*CW-1:0] cmd_mem [MAX_SAMPLES];
    logic [2*CW-1:0] pos_rd_reg, cmd_rd_reg;
    logic            cmd_we;
    logic [SA_W-1:0] cmd_waddr;
    logic [2*CW-1:0] cmd_wdata;

    always_ff @(posedge aclk) begin
        if (s_acc && is_run) begin
            pos_mem[use_s] <= {s_meas_x, s_meas_y};
        end
        if (s_acc && is_run) begin
            pos_rd_reg <= pos_mem[use_s];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_we) begin
            cmd_mem[cmd_waddr] <= cmd_wdata;
        end
        if (s_acc && is_run) begin
            cmd_rd_reg <= cmd_mem[use_s];
        end
    end

    // last command write, for forwarding
    logic            wb_valid_reg;
    logic [SA_W-1:0] wb_addr_reg;
    logic [2*CW-1:0] wb_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else begin
            wb_valid_reg <= cmd_we;
        end
        wb_addr_reg <= cmd_waddr;
        wb_data_reg <= cmd_wdata;
    end

    // stage 1: table and sample data
    logic              s1_valid_reg;
    logic              s1_hold_reg, s1_learn_reg, s1_ovf_reg, s1_wp_ok_reg;
    logic [IDX_W-1:0]  s1_wp_reg;
    logic [PASS_W-1:0] s1_pass_reg;
    logic [SA_W-1:0]   s1_addr_reg;
    logic signed [CW-1:0] s1_mx_reg, s1_my_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_acc && is_tick;
        end
        s1_hold_reg  <= !is_run;
        s1_learn_reg <= is_run && (pass_next != '0);
        s1_ovf_reg   <= ovf_now;
        s1_wp_ok_reg <= rd_wp_ok;
        s1_wp_reg    <= wp_next;
        s1_pass_reg  <= pass_next;
        s1_addr_reg  <= use_s;
        s1_mx_reg    <= s_meas_x;
        s1_my_reg    <= s_meas_y;
    end

    logic signed [CW-1:0]     t_wx, t_wy, t_fx, t_fy, p_x, p_y;
    logic signed [CW:0]       diff_x, diff_y, err_full_x, err_full_y;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic [2*CW-1:0]          u1, direct1;
    logic signed [CW-1:0]     ex1, ey1;

    assign {t_wx, t_wy, t_fx, t_fy} = s1_wp_ok_reg ? tbl_rd_reg : '0;
    assign {p_x, p_y} = pos_rd_reg;
    assign diff_x = (CW + 1)'(t_wx) - (CW + 1)'(p_x);
    assign diff_y = (CW + 1)'(t_wy) - (CW + 1)'(p_y);
    assign gain_s = {1'b0, gain_reg};
    assign prod_x = PROD_W'(gain_s) * PROD_W'(diff_x);
    assign prod_y = PROD_W'(gain_s) * PROD_W'(diff_y);
    assign err_full_x = (CW + 1)'(t_wx) - (CW + 1)'(s1_mx_reg);
    assign err_full_y = (CW + 1)'(t_wy) - (CW + 1)'(s1_my_reg);
    assign ex1 = s1_hold_reg ? '0 : sat_diff(err_full_x);
    assign ey1 = s1_hold_reg ? '0 : sat_diff(err_full_y);
    assign direct1 = (s1_pass_reg != '0) ? {t_wx, t_wy} : {t_fx, t_fy};
    assign u1 = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg : cmd_rd_reg;

    // stage 2: round, accumulate, saturate
    logic              s2_valid_reg;
    logic              s2_hold_reg, s2_learn_reg, s2_ovf_reg;
    logic [IDX_W-1:0]  s2_wp_reg;
    logic [PASS_W-1:0] s2_pass_reg;
    logic [SA_W-1:0]   s2_addr_reg;
    logic signed [PROD_W-1:0] s2_prod_x_reg, s2_prod_y_reg;
    logic [2*CW-1:0]   s2_u_reg, s2_direct_reg;
    logic signed [CW-1:0] s2_ex_reg, s2_ey_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
        s2_hold_reg   <= s1_hold_reg;
        s2_learn_reg  <= s1_learn_reg;
        s2_ovf_reg    <= s1_ovf_reg;
        s2_wp_reg     <= s1_wp_reg;
        s2_pass_reg   <= s1_pass_reg;
        s2_addr_reg   <= s1_addr_reg;
        s2_prod_x_reg <= prod_x;
        s2_prod_y_reg <= prod_y;
        s2_u_reg      <= u1;
        s2_direct_reg <= direct1;
        s2_ex_reg     <= ex1;
        s2_ey_reg     <= ey1;
    end

    logic [2*CW-1:0]         u2;
    logic signed [CW-1:0]    u2_x, u2_y, dir_x, dir_y, cmd_x, cmd_y;
    logic signed [SUM_W-1:0] rnd_x, rnd_y, sum_x, sum_y;

    assign u2 = (wb_valid_reg && (wb_addr_reg == s2_addr_reg)) ? wb_data_reg : s2_u_reg;
    assign {u2_x, u2_y}   = u2;
    assign {dir_x, dir_y} = s2_direct_reg;
    assign rnd_x = SUM_W'(s2_prod_x_reg) + SUM_W'(ROUND_HALF);
    assign rnd_y = SUM_W'(s2_prod_y_reg) + SUM_W'(ROUND_HALF);
    assign sum_x = (rnd_x >>> FRAC_BITS) + SUM_W'(u2_x);
    assign sum_y = (rnd_y >>> FRAC_BITS) + SUM_W'(u2_y);
    assign cmd_x = s2_learn_reg ? sat_sum(sum_x) : dir_x;
    assign cmd_y = s2_learn_reg ? sat_sum(sum_y) : dir_y;

    assign cmd_we    = s2_valid_reg && !s2_hold_reg;
    assign cmd_waddr = s2_addr_reg;
    assign cmd_wdata = {cmd_x, cmd_y};

    // output queue
    logic [RES_W-1:0]   fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_CW:0]   in_use;
    logic               push, pop;

    assign push = s2_valid_reg;
    assign pop  = m_valid && m_ready;
    assign in_use = (FIFO_CW + 1)'(count_reg) + (FIFO_CW + 1)'(s1_valid_reg)
                  + (FIFO_CW + 1)'(s2_valid_reg);
    assign s_ready = (in_use < (FIFO_CW + 1)'(FIFO_DEPTH));
    assign m_valid = (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {cmd_x, cmd_y, s2_ex_reg, s2_ey_reg, s2_wp_reg,
                                     s2_pass_reg, s2_hold_reg, s2_ovf_reg};
        end
    end

    assign {m_command_x, m_command_y, m_error_x, m_error_y, m_waypoint_now,
            m_pass_number, m_holding, m_sample_overflow} = fifo_mem[rd_ptr_reg];

endmodule

>>> src/ilwc_checker.sv
module ilwc_checker
    import ilwc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [COORD_WIDTH-1:0] m_command_x,
    input logic signed [COORD_WIDTH-1:0] m_error_x,
    input logic signed [COORD_WIDTH-1:0] m_error_y,
    input logic [IDX_W-1:0]              m_waypoint_now,
    input logic [PASS_W-1:0]             m_pass_number,
    input logic                          m_holding,
    input logic                          m_sample_overflow
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command_x)
            && $stable(m_waypoint_now) && $stable(m_pass_number) && $stable(m_holding))
        else $error("result changed while stalled");

    // hold-mode results carry no error and no overflow
    a_hold_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_holding |-> (m_error_x == '0) && (m_error_y == '0)
            && !m_sample_overflow)
        else $error("hold result with error or overflow");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind iterative_learning_waypoint_control_unit ilwc_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_ilwc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_command_x       (m_command_x),
    .m_error_x         (m_error_x),
    .m_error_y         (m_error_y),
    .m_waypoint_now    (m_waypoint_now),
    .m_pass_number     (m_pass_number),
    .m_holding         (m_holding),
    .m_sample_overflow (m_sample_overflow)
);

>>> test/tb_iterative_learning_waypoint_control_unit.sv
module tb_iterative_learning_waypoint_control_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ilwc_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int NUM_WP      = MAX_WAYPOINTS_DEF;
    localparam int NUM_SAMPLES = MAX_SAMPLES_DEF;
    localparam longint CMAX    = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN    = -(longint'(1) << (CW - 1));
    localparam int QUIET_LIMIT = 4000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        logic             req_type;
        logic [IDX_W-1:0] entry_index;
        coord_t           want_x, want_y, first_x, first_y, meas_x, meas_y;
        logic             control_on, waypoints_on;
    } path_req_t;

    typedef struct {
        coord_t            command_x, command_y, error_x, error_y;
        logic [IDX_W-1:0]  waypoint_now;
        logic [PASS_W-1:0] pass_number;
        logic              holding, sample_overflow;
    } command_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_req_type = REQ_LOAD;
    logic [IDX_W-1:0] s_entry_index = '0;
    coord_t           s_want_x = '0, s_want_y = '0, s_first_x = '0, s_first_y = '0;
    coord_t           s_meas_x = '0, s_meas_y = '0;
    logic             s_control_on = 1'b0;
    logic             s_waypoints_on = 1'b0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    coord_t            m_command_x, m_command_y, m_error_x, m_error_y;
    logic [IDX_W-1:0]  m_waypoint_now;
    logic [PASS_W-1:0] m_pass_number;
    logic              m_holding;
    logic              m_sample_overflow;

    iterative_learning_waypoint_control_unit uut (.*);

    // controller model state
    coord_t wp_want_x[NUM_WP], wp_want_y[NUM_WP], wp_first_x[NUM_WP], wp_first_y[NUM_WP];
    coord_t hist_cmd_x[NUM_SAMPLES], hist_cmd_y[NUM_SAMPLES];
    coord_t hist_pos_x[NUM_SAMPLES], hist_pos_y[NUM_SAMPLES];
    int unsigned tick_cnt = 0, wp_cur = 0, sample_cur = 0, pass_cnt = 0;
    bit          pass_live = 1'b0;
    logic [GAIN_W-1:0] gain_val = GAIN_RST;
    logic [THR_W-1:0]  thr_val  = THRESHOLD_RST;
    logic [IDX_W-1:0]  last_val = LAST_WP_RST;

    path_req_t path_requests[$];
    command_t  expected_cmds[$];
    int        issued = 0;
    int        sent_count = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        hold_at = 32'h7fffffff;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    path_req_t cur_req;
    command_t  head;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic coord_t clamp_coord(longint v);
        if (v > CMAX) return coord_t'(CMAX);
        if (v < CMIN) return coord_t'(CMIN);
        return coord_t'(v);
    endfunction

    // u = prev_u + round(rho * (desired - prev_pos)), ties toward +inf
    function automatic coord_t learn_axis(coord_t prev_u, coord_t want, coord_t prev_pos);
        longint diff, term;
        diff = longint'(want) - longint'(prev_pos);
        term = (longint'(gain_val) * diff + ROUND_HALF) >>> FRAC_BITS;
        return clamp_coord(longint'(prev_u) + term);
    endfunction

    function automatic bit step_controller(input path_req_t r, output command_t c);
        bit          hold;
        int unsigned s;
        coord_t      wx, wy, fx, fy;
        c = '{default: '0};
        if (r.req_type == REQ_LOAD) begin
            wp_want_x[r.entry_index]  = r.want_x;
            wp_want_y[r.entry_index]  = r.want_y;
            wp_first_x[r.entry_index] = r.first_x;
            wp_first_y[r.entry_index] = r.first_y;
            return 1'b0;
        end
        if (!r.control_on) return 1'b0;
        hold = !r.waypoints_on;
        if (!hold) begin
            if (tick_cnt < 32'hffff) tick_cnt++;
            if (tick_cnt > thr_val) begin
                tick_cnt = 0;
                if (wp_cur < last_val) begin
                    if (pass_live) wp_cur = (wp_cur + 1) % NUM_WP;
                end else begin
                    wp_cur = 0;
                    sample_cur = 0;
                    if (pass_cnt < 32'hffff) pass_cnt++;
                    pass_live = 1'b0;
                end
            end
        end
        wx = wp_want_x[wp_cur];
        wy = wp_want_y[wp_cur];
        fx = wp_first_x[wp_cur];
        fy = wp_first_y[wp_cur];
        c.waypoint_now = IDX_W'(wp_cur);
        c.pass_number  = PASS_W'(pass_cnt);
        c.holding      = hold;
        if (hold) begin
            c.command_x = (pass_cnt == 0) ? fx : wx;
            c.command_y = (pass_cnt == 0) ? fy : wy;
        end else begin
            s = sample_cur;
            if (s >= NUM_SAMPLES - 1) begin
                s = NUM_SAMPLES - 1;
                c.sample_overflow = 1'b1;
            end
            if (pass_cnt == 0) begin
                c.command_x = fx;
                c.command_y = fy;
            end else begin
                c.command_x = learn_axis(hist_cmd_x[s], wx, hist_pos_x[s]);
                c.command_y = learn_axis(hist_cmd_y[s], wy, hist_pos_y[s]);
            end
            hist_cmd_x[s] = c.command_x;
            hist_cmd_y[s] = c.command_y;
            hist_pos_x[s] = r.meas_x;
            hist_pos_y[s] = r.meas_y;
            c.error_x = clamp_coord(longint'(wx) - longint'(r.meas_x));
            c.error_y = clamp_coord(longint'(wy) - longint'(r.meas_y));
            if (!c.sample_overflow) sample_cur = s + 1;
            pass_live = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(7))
            0: return coord_t'(CMIN);
            1: return coord_t'(CMAX);
            2: return '0;
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic path_req_t rand_req();
        path_req_t r;
        r.req_type     = REQ_TICK;
        r.entry_index  = IDX_W'($urandom);
        r.want_x       = rand_coord();
        r.want_y       = rand_coord();
        r.first_x      = rand_coord();
        r.first_y      = rand_coord();
        r.meas_x       = rand_coord();
        r.meas_y       = rand_coord();
        r.control_on   = 1'b1;
        r.waypoints_on = 1'b1;
        return r;
    endfunction

    function automatic int sender_idle_pct();
        if (sent_count < 550) return 37;
        if (sent_count < 1100) return 84;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (sent_count < 550) return 84;
        if (sent_count < 1100) return 37;
        return 0;
    endfunction

    task automatic queue_item(input path_req_t r);
        command_t c;
        if (step_controller(r, c)) expected_cmds = {expected_cmds, c};
        path_requests = {path_requests, r};
        issued++;
    endtask

    task automatic push_tick(logic ctrl, logic run, coord_t mx, coord_t my);
        path_req_t r;
        r = rand_req();
        r.control_on   = ctrl;
        r.waypoints_on = run;
        r.meas_x       = mx;
        r.meas_y       = my;
        queue_item(r);
    endtask

    task automatic push_load(int entry, coord_t wx, coord_t wy, coord_t fx, coord_t fy);
        path_req_t r;
        r = rand_req();
        r.req_type    = REQ_LOAD;
        r.entry_index = IDX_W'(entry);
        r.want_x      = wx;
        r.want_y      = wy;
        r.first_x     = fx;
        r.first_y     = fy;
        queue_item(r);
    endtask

    // mostly learning ticks, the rest hold ticks, inactive ticks and table loads
    task automatic gen_one(input int run_pct);
        path_req_t r;
        int        k;
        r = rand_req();
        k = $urandom_range(99);
        if (k >= run_pct) begin
            case (k % 3)
                0: r.waypoints_on = 1'b0;
                1: begin
                    r.control_on   = 1'b0;
                    r.waypoints_on = 1'($urandom_range(1));
                end
                default: r.req_type = REQ_LOAD;
            endcase
        end
        queue_item(r);
    endtask

    task automatic drain_wait();
        do @(posedge aclk);
        while (path_requests.size() != 0 || s_valid || expected_cmds.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(logic [GAIN_W-1:0] g, logic [THR_W-1:0] t,
                              logic [IDX_W-1:0] l);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_GAIN;
        cfg_wdata <= CFG_DATA_W'(g);
        @(posedge aclk);
        cfg_addr  <= CFG_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(t);
        @(posedge aclk);
        cfg_addr  <= CFG_LAST_WP;
        cfg_wdata <= CFG_DATA_W'(l);
        @(posedge aclk);
        cfg_we <= 1'b0;
        gain_val = g;
        thr_val  = t;
        last_val = l;
    endtask

    task automatic run_phase(logic [GAIN_W-1:0] g, logic [THR_W-1:0] t,
                             logic [IDX_W-1:0] l, int n);
        drain_wait();
        set_config(g, t, l);
        repeat (n) gen_one(80);
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t ns transaction mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) sent_count++;
            if (!s_valid || s_ready) begin
                if (path_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    cur_req = path_requests.pop_front();
                    s_req_type     <= cur_req.req_type;
                    s_entry_index  <= cur_req.entry_index;
                    s_want_x       <= cur_req.want_x;
                    s_want_y       <= cur_req.want_y;
                    s_first_x      <= cur_req.first_x;
                    s_first_y      <= cur_req.first_y;
                    s_meas_x       <= cur_req.meas_x;
                    s_meas_y       <= cur_req.meas_y;
                    s_control_on   <= cur_req.control_on;
                    s_waypoints_on <= cur_req.waypoints_on;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    head = expected_cmds.pop_front();
                    check_field("command_x", 32'(m_command_x), 32'(head.command_x));
                    check_field("command_y", 32'(m_command_y), 32'(head.command_y));
                    check_field("error_x", 32'(m_error_x), 32'(head.error_x));
                    check_field("error_y", 32'(m_error_y), 32'(head.error_y));
                    check_field("waypoint_now", 32'(m_waypoint_now),
                                32'(head.waypoint_now));
                    check_field("pass_number", 32'(m_pass_number), 32'(head.pass_number));
                    check_field("holding", 32'(m_holding), 32'(head.holding));
                    check_field("sample_overflow", 32'(m_sample_overflow),
                                32'(head.sample_overflow));
                end
            end
            if (!hold_done && sent_count >= hold_at) begin
                hold_left = 300;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int guard;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // long first pass so every sample entry that a later pass
        // reads is written before learning reads it
        set_config(15'd3000, 16'd9, 6'd63);
        push_load(0, coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX));
        for (int i = 1; i < NUM_WP; i++)
            push_load(i, rand_coord(), rand_coord(), rand_coord(), rand_coord());

        push_tick(1'b1, 1'b0, '0, '0);
        push_tick(1'b0, 1'b1, rand_coord(), rand_coord());
        push_tick(1'b0, 1'b0, rand_coord(), rand_coord());
        push_tick(1'b1, 1'b1, coord_t'(CMIN), coord_t'(CMAX));
        push_tick(1'b1, 1'b1, coord_t'(CMAX), coord_t'(CMIN));
        push_tick(1'b1, 1'b1, '0, '0);
        push_load(0, coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMIN));
        push_tick(1'b1, 1'b1, coord_t'(CMAX), coord_t'(CMIN));
        push_tick(1'b1, 1'b0, rand_coord(), rand_coord());

        guard = 0;
        while (pass_cnt == 0 && guard < 5000) begin
            gen_one(90);
            guard++;
        end
        repeat (40) gen_one(90);

        run_phase(15'd0, 16'd0, 6'd0, 100);
        run_phase(15'h7fff, 16'd2, 6'd3, 250);
        hold_at = issued - 200;
        run_phase(GAIN_RST, 16'hffff, 6'd63, 60);
        run_phase(GAIN_W'($urandom), THR_W'($urandom_range(4)),
                  IDX_W'($urandom_range(10, 1)), 150);
        run_phase(GAIN_W'($urandom), 16'd1, 6'd63, 150);
        run_phase(GAIN_W'($urandom), 16'd0, 6'd7, 100);

        drain_wait();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
